FILE: rtl/mrfc_pkg.sv
`timescale 1ns / 1ps

package mrfc_pkg;

  localparam int COUNT_LIMIT_DEF = 255;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [7:0] START_BYTE = 8'hC0;
  localparam logic [7:0] MARK_BYTE = 8'hBC;
  localparam logic [7:0] DOT_BYTE = 8'h2E;
  localparam logic [7:0] SUM_MASK = 8'h7F;
  localparam int FIELD_FIRST = 5;
  localparam int FIELD_LAST = 12;
  localparam logic [3:0] FIELD_DIGITS = 4'd7;
  localparam logic [3:0] DIGIT_CNT_MAX = 4'd15;

  localparam logic [7:0] STATION_ID_RST = 8'd1;
  localparam logic [7:0] MAX_LEN_RST = 8'd30;
  localparam logic [7:0] ECHO_LEN_RST = 8'd5;

  localparam int READING_W = 24;

  typedef enum logic [1:0] {
    REG_STATION_ID = 2'd0,
    REG_MAX_LEN    = 2'd1,
    REG_ECHO_LEN   = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ECHO     = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_FRAMING  = 3'd3,
    ST_CHECKSUM = 3'd4,
    ST_FORMAT   = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] station_id;
    logic [7:0] max_reply_length;
    logic [7:0] echo_length;
  } cfg_t;

endpackage

FILE: rtl/mrfc_frame.sv
`timescale 1ns / 1ps

module mrfc_frame #(
  parameter int COUNT_LIMIT = mrfc_pkg::COUNT_LIMIT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic [7:0]                         rx_byte,
  input  logic                               end_of_reply,
  input  mrfc_pkg::cfg_t                     cfg,
  output mrfc_pkg::status_t                  status,
  output logic [mrfc_pkg::READING_W-1:0]     reading
);

  import mrfc_pkg::*;

  localparam int CW = $clog2(COUNT_LIMIT + 2);
  localparam int CMPW = (CW > 8) ? CW : 8;

  logic [CW-1:0]        byte_count;
  logic [7:0]           running_sum;
  logic [7:0]           previous_byte;
  logic                 header_ok;
  logic [READING_W-1:0] digit_value;
  logic [3:0]           digit_count;
  logic                 bad_char;

  logic                 header_ok_next;
  logic [READING_W-1:0] digit_value_next;
  logic [3:0]           digit_count_next;
  logic                 bad_char_next;
  logic                 in_field;
  logic                 is_digit;
  logic [CW-1:0]        len;
  logic [7:0]           crc;

  always_comb begin
    header_ok_next = header_ok;
    if (byte_count == CW'(0) && rx_byte != START_BYTE) header_ok_next = 1'b0;
    if (byte_count == CW'(1) && rx_byte != cfg.station_id) header_ok_next = 1'b0;
    if (byte_count == CW'(3) && rx_byte != MARK_BYTE) header_ok_next = 1'b0;

    in_field = (byte_count >= CW'(FIELD_FIRST)) && (byte_count <= CW'(FIELD_LAST));
    is_digit = rx_byte inside {[8'h30:8'h39]};

    digit_value_next = digit_value;
    digit_count_next = digit_count;
    bad_char_next = bad_char;
    if (in_field) begin
      if (is_digit) begin
        digit_value_next = READING_W'(digit_value * READING_W'(10))
                           + READING_W'(rx_byte[3:0]);
        if (digit_count != DIGIT_CNT_MAX) digit_count_next = digit_count + 4'd1;
      end else if (rx_byte != DOT_BYTE) begin
        bad_char_next = 1'b1;
      end
    end

    len = byte_count + CW'(1);
    crc = 8'((~running_sum & SUM_MASK) - 8'd1);

    reading = '0;
    if (byte_count >= CW'(COUNT_LIMIT)) begin
      status = ST_TOO_LONG;
    end else if (CMPW'(len) <= CMPW'(cfg.echo_length)) begin
      status = ST_ECHO;
    end else if (CMPW'(len) > CMPW'(cfg.max_reply_length)) begin
      status = ST_TOO_LONG;
    end else if (!header_ok_next || len < CW'(4) || previous_byte != MARK_BYTE) begin
      status = ST_FRAMING;
    end else if (crc != rx_byte) begin
      status = ST_CHECKSUM;
    end else if (bad_char_next || len < CW'(FIELD_LAST + 1)
                 || digit_count_next != FIELD_DIGITS) begin
      status = ST_FORMAT;
    end else begin
      status = ST_OK;
      reading = digit_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      running_sum <= '0;
      previous_byte <= '0;
      header_ok <= 1'b1;
      digit_value <= '0;
      digit_count <= '0;
      bad_char <= 1'b0;
    end else if (accept) begin
      if (end_of_reply) begin
        byte_count <= '0;
        running_sum <= '0;
        previous_byte <= '0;
        header_ok <= 1'b1;
        digit_value <= '0;
        digit_count <= '0;
        bad_char <= 1'b0;
      end else begin
        if (byte_count <= CW'(COUNT_LIMIT)) byte_count <= byte_count + CW'(1);
        running_sum <= running_sum + rx_byte;
        previous_byte <= rx_byte;
        header_ok <= header_ok_next;
        digit_value <= digit_value_next;
        digit_count <= digit_count_next;
        bad_char <= bad_char_next;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CW'(COUNT_LIMIT + 1))
    else $error("byte count past saturation");

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_reply |=> byte_count == '0 && running_sum == '0 && header_ok
                               && digit_count == '0 && !bad_char)
    else $error("frame state not cleared after last item");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    accept && !end_of_reply && byte_count <= CW'(COUNT_LIMIT)
    |=> byte_count == $past(byte_count) + CW'(1))
    else $error("byte count did not advance");

endmodule

FILE: rtl/meter_response_frame_checker.sv
`timescale 1ns / 1ps

// Latency: a result appears in the cycle after the final item of a reply is taken.
// Throughput: one item per cycle; a result not yet taken by out_ready stalls in_ready.
// Per-byte work is one registered step of the frame state (sum, count, x10 digit update).
// Synchronous active-high reset clears the frame state and output valid, and loads
// station_id = 1, max_reply_length = 30, echo_length = 5.
module meter_response_frame_checker #(
  parameter int COUNT_LIMIT = mrfc_pkg::COUNT_LIMIT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mrfc_pkg::ADDR_W-1:0]        paddr,
  input  logic [mrfc_pkg::DATA_W-1:0]        pwdata,
  output logic [mrfc_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         rx_byte,
  input  logic                               end_of_reply,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         status_code,
  output logic [mrfc_pkg::READING_W-1:0]     reading
);

  import mrfc_pkg::*;

  cfg_t                 cfg;
  reg_idx_t             reg_idx;
  logic                 accept;
  status_t              frame_status;
  logic [READING_W-1:0] frame_reading;

  assign pready = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.station_id <= STATION_ID_RST;
      cfg.max_reply_length <= MAX_LEN_RST;
      cfg.echo_length <= ECHO_LEN_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_STATION_ID: cfg.station_id <= pwdata[7:0];
        REG_MAX_LEN:    cfg.max_reply_length <= pwdata[7:0];
        REG_ECHO_LEN:   cfg.echo_length <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_STATION_ID: prdata = DATA_W'(cfg.station_id);
      REG_MAX_LEN:    prdata = DATA_W'(cfg.max_reply_length);
      REG_ECHO_LEN:   prdata = DATA_W'(cfg.echo_length);
      default:        prdata = '0;
    endcase
  end

  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;

  mrfc_frame #(
    .COUNT_LIMIT(COUNT_LIMIT)
  ) u_frame (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .rx_byte      (rx_byte),
    .end_of_reply (end_of_reply),
    .cfg          (cfg),
    .status       (frame_status),
    .reading      (frame_reading)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= end_of_reply;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && end_of_reply) begin
      status_code <= frame_status;
      reading <= frame_reading;
    end
  end

  a_no_result_mid: assert property (@(posedge clk) disable iff (rst)
    accept && !end_of_reply |=> !out_valid)
    else $error("result raised by a non-final item");

  a_result_on_last: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_reply |=> out_valid)
    else $error("final item gave no result");

  a_reading_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && status_code != ST_OK |-> reading == '0)
    else $error("reading set on a failed reply");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status_code <= ST_FORMAT)
    else $error("status code out of range");

endmodule
